>>> rtl/core/bra_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator package
// Shared payload types, request and status codes, and the control and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bra_pkg;

   // Default number of map bytes and the reset value of the size register.
   localparam int          MAP_BYTES_DEFAULT  = 128;
   localparam logic [7:0]  ACTIVE_BYTES_RESET = 8'd128;

   // A unit index has 10 bits, so at most 128 bytes can ever be reached.
   localparam int          REACH_BYTES        = 128;

   // Request modes.
   localparam logic [1:0]  MODE_TEST   = 2'd0;
   localparam logic [1:0]  MODE_SET    = 2'd1;
   localparam logic [1:0]  MODE_CLEAR  = 2'd2;
   localparam logic [1:0]  MODE_SEARCH = 2'd3;

   // Result status codes.
   localparam logic [1:0]  STATUS_OK        = 2'd0;
   localparam logic [1:0]  STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0]  STATUS_RANGE     = 2'd2;

   // One request item.
   typedef struct packed {
      logic [1:0]  mode;
      logic [9:0]  unit_index;
      logic [10:0] run_length;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [1:0]  status;
      logic        bit_used;
      logic [9:0]  run_start;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load;        // capture the request
      logic        clr_step;    // zero one map byte of the clearing pass
      logic        rd_index;    // read the byte that holds the indexed unit
      logic        scan_first;  // start a search at byte zero
      logic        scan_next;   // advance the search by one byte
      logic        modify;      // read data of the indexed byte is present
      logic        respond;     // register a result this cycle
      logic [1:0]  rsp_status;  // status of that result
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic        clear_last;  // clearing pass is at its last byte
      logic        is_search;   // captured request is a search
      logic        none_search; // search cannot find anything
      logic        out_range;   // captured index is beyond the active units
      logic        found;       // current byte completes the wanted run
      logic        last_byte;   // current byte is the last active byte
   } stat_type;

endpackage

>>> rtl/core/bra_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array with a registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/bra_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator controller
// Sequences the clearing pass, single-bit requests and the byte-wise search.
// ----------------------------------------------------------------------------
module bra_ctrl import bra_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_MODIFY,
      ST_SCAN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   // Command decode for the current state.
   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.load = start;
            if (start) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.is_search) begin
               if (stat.none_search) begin
                  cmd.respond = 1'b1;
                  cmd.rsp_status = STATUS_NOT_FOUND;
                  state_in = ST_IDLE;
               end else begin
                  cmd.scan_first = 1'b1;
                  state_in = ST_SCAN;
               end
            end else if (stat.out_range) begin
               cmd.respond = 1'b1;
               cmd.rsp_status = STATUS_RANGE;
               state_in = ST_IDLE;
            end else begin
               cmd.rd_index = 1'b1;
               state_in = ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            cmd.modify = 1'b1;
            cmd.respond = 1'b1;
            cmd.rsp_status = STATUS_OK;
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (stat.found) begin
               cmd.respond = 1'b1;
               cmd.rsp_status = STATUS_OK;
               state_in = ST_IDLE;
            end else if (stat.last_byte) begin
               cmd.respond = 1'b1;
               cmd.rsp_status = STATUS_NOT_FOUND;
               state_in = ST_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and the registered busy flag; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

>>> rtl/core/bra_datapath.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator datapath
// Holds the size register, the request, the occupancy memory, the search
// pointers and run counter, and the result register.
// ----------------------------------------------------------------------------
module bra_datapath import bra_pkg::*; #(
   parameter int MAP_BYTES = MAP_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  logic       csr_write,
   input  logic [7:0] csr_data,
   input  cmd_type    cmd,
   output stat_type   stat,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int CAP_BYTES = (MAP_BYTES < REACH_BYTES) ? MAP_BYTES : REACH_BYTES;

   typedef struct packed {
      logic        found;
      logic [10:0] run;
      logic [9:0]  start;
   } scan_type;

   // Walk the eight units of one byte, lowest first, carrying the run length.
   function automatic scan_type scan_byte(input logic [7:0]  bits,
                                          input logic [10:0] run_in,
                                          input logic [10:0] len,
                                          input logic [9:0]  base);
      scan_type res;
      res.found = 1'b0;
      res.run   = run_in;
      res.start = '0;
      for (int j = 0; j < 8; j++) begin
         if (!res.found) begin
            if (bits[j]) begin
               res.run = '0;
            end else begin
               res.run = res.run + 11'd1;
               if (res.run == len) begin
                  res.found = 1'b1;
                  res.start = 10'({1'b0, base} + 11'(j) + 11'd1 - len);
               end
            end
         end
      end
      return res;
   endfunction

   req_type     req_ff;
   logic [7:0]  active_ff;
   logic [AW-1:0] clr_ff;
   logic [7:0]  cur_ff;
   logic [10:0] run_ff;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;

   logic [7:0]    eff_bytes;
   logic [7:0]    ram_rd;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [AW-1:0] index_addr;
   logic [7:0]    bit_mask;
   logic          test_bit;
   scan_type      scan_res;

   // Active byte count, limited by the memory size and the index reach.
   assign eff_bytes = (active_ff > 8'(CAP_BYTES)) ? 8'(CAP_BYTES) : active_ff;

   // Decode of the captured request.
   assign index_addr = AW'(req_ff.unit_index[9:3]);
   assign bit_mask   = 8'd1 << req_ff.unit_index[2:0];
   assign test_bit   = ram_rd[req_ff.unit_index[2:0]];
   assign scan_res   = scan_byte(ram_rd, run_ff, req_ff.run_length, {cur_ff[6:0], 3'b000});

   assign stat.clear_last  = (clr_ff == AW'(MAP_BYTES - 1));
   assign stat.is_search   = (req_ff.mode == MODE_SEARCH);
   assign stat.none_search = (req_ff.run_length == '0) || (eff_bytes == '0);
   assign stat.out_range   = ({1'b0, req_ff.unit_index[9:3]} >= eff_bytes);
   assign stat.found       = scan_res.found;
   assign stat.last_byte   = ((cur_ff + 8'd1) == eff_bytes);

   // Memory write: zero fill during the clearing pass, else a bit update.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = index_addr;
      ram_wr_data = ram_rd;
      if (cmd.clr_step) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = '0;
      end else if (cmd.modify) begin
         case (req_ff.mode)
            MODE_SET: begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd | bit_mask;
            end
            MODE_CLEAR: begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd & ~bit_mask;
            end
            default: begin
               ram_wr_en = 1'b0;
            end
         endcase
      end
   end

   // Memory read address: the indexed byte, byte zero, or the next byte.
   always_comb begin
      ram_rd_en   = cmd.rd_index | cmd.scan_first | cmd.scan_next;
      ram_rd_addr = index_addr;
      if (cmd.scan_first) begin
         ram_rd_addr = '0;
      end else if (cmd.scan_next) begin
         ram_rd_addr = AW'(cur_ff[6:0] + 7'd1);
      end
   end

   bra_ram #(
      .WIDTH (8),
      .DEPTH (MAP_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd)
   );

   // Control registers: size register, clearing counter and result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= ACTIVE_BYTES_RESET;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            active_ff <= csr_data;
         end
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + AW'(1);
         end
         rsp_valid_ff <= cmd.respond;
      end
   end

   // Request capture, search pointer and run counter.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.scan_first) begin
         cur_ff <= '0;
         run_ff <= '0;
      end else if (cmd.scan_next) begin
         cur_ff <= cur_ff + 8'd1;
         run_ff <= scan_res.run;
      end
   end

   // Result register; fields not meant for the mode read as zero.
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_ff.status    <= cmd.rsp_status;
         rsp_ff.bit_used  <= cmd.modify && (req_ff.mode == MODE_TEST) && test_bit;
         rsp_ff.run_start <= ((cmd.rsp_status == STATUS_OK) && stat.is_search)
                             ? scan_res.start : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/core/bitmap_run_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator
// First-fit occupancy map with one bit per unit: test, set, clear and
// free-run search.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low. busy
//   stays high until the result is shown. Each result appears on rsp_data
//   for exactly one cycle with rsp_valid high; the receiver cannot stall it.
//   busy drops in that same cycle, so the next request can be transferred
//   while the result is on the ports.
//   Path from the accepted request to the result:
//     out-of-range index or empty search: result from the decode state,
//     test, set, clear: one memory read, then the write with the result,
//     search: one byte read per scan state up to the one that completes
//     the run, at most the active byte count.
//   The search reads the single memory port one byte per cycle; that port
//   sets the search rate.
//   Reset clears the map in a pass over all MAP_BYTES bytes, one byte a cycle,
//   with busy high. The size register is written over the csr_ channel,
//   which is always ready, including during the clearing pass.
// ----------------------------------------------------------------------------
module bitmap_run_allocator import bra_pkg::*; #(
   parameter int MAP_BYTES = MAP_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   // The size register accepts a transfer in every cycle.
   assign csr_ready = 1'b1;

   bra_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   bra_datapath #(
      .MAP_BYTES (MAP_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/core/bra_checker.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator checker
// Port-level properties of the request and result channels.
// ----------------------------------------------------------------------------
module bra_checker import bra_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // An accepted request holds the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a request transfer");

   // A result follows a busy cycle and is never shown twice in a row.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !$past(rsp_valid)))
      else $error("result strobe without a request in progress");

   // Only the three defined status codes appear.
   a_rsp_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_OK ||
                     rsp_data.status == STATUS_NOT_FOUND ||
                     rsp_data.status == STATUS_RANGE))
      else $error("undefined result status");

   // A failed request reports no bit and no run start.
   a_rsp_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_OK) |->
         (!rsp_data.bit_used && rsp_data.run_start == '0))
      else $error("failed request carries result data");

endmodule

bind bitmap_run_allocator bra_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

>>> dv/bra_result_checker.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator result checker
// Watches the request, result and size register channels, keeps its own copy
// of the occupancy map, predicts every result and compares it with the block.
// ----------------------------------------------------------------------------
module bra_result_checker import bra_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  rsp_type    rsp_data,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [7:0] csr_data,
   output int         mismatches,
   output int         outstanding
);

   // Shadow occupancy map, one bit per unit, and the shadow size register.
   logic [7:0] occupancy [MAP_BYTES_DEFAULT];
   logic [7:0] active_bytes;
   rsp_type    expected_rsp_q [$];

   // Number of units in use, limited by the map size and the index reach.
   function automatic int active_units();
      int bytes_used;
      bytes_used = (active_bytes > MAP_BYTES_DEFAULT) ? MAP_BYTES_DEFAULT : active_bytes;
      return (bytes_used * 8 > 1024) ? 1024 : bytes_used * 8;
   endfunction

   // Applies one request to the shadow map and returns the result it gives.
   function automatic rsp_type allocate_step(req_type r);
      rsp_type res;
      int      units;
      int      run;
      int      u;
      res   = '0;
      units = active_units();
      if (r.mode == MODE_SEARCH) begin
         // First fit: the scan stops at the first unit that completes the run.
         res.status = STATUS_NOT_FOUND;
         run = 0;
         if (r.run_length != 0) begin
            for (u = 0; u < units && res.status != STATUS_OK; u++) begin
               if (occupancy[u / 8][u % 8]) begin
                  run = 0;
               end else begin
                  run++;
                  if (run == r.run_length) begin
                     res.status    = STATUS_OK;
                     res.run_start = 10'(u + 1 - run);
                  end
               end
            end
         end
      end else if (r.unit_index >= units) begin
         res.status = STATUS_RANGE;
      end else begin
         case (r.mode)
            MODE_TEST:  res.bit_used = occupancy[r.unit_index >> 3][r.unit_index[2:0]];
            MODE_SET:   occupancy[r.unit_index >> 3][r.unit_index[2:0]] = 1'b1;
            MODE_CLEAR: occupancy[r.unit_index >> 3][r.unit_index[2:0]] = 1'b0;
            default: ;
         endcase
      end
      return res;
   endfunction

   // Everything is sampled at the rising edge. A result leaving the queue is
   // handled before a new request enters it, since both can share one edge.
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         foreach (occupancy[i]) occupancy[i] = '0;
         active_bytes = ACTIVE_BYTES_RESET;
         expected_rsp_q.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            active_bytes = csr_data;
         end
         if (rsp_valid) begin
            if (expected_rsp_q.size() == 0) begin
               if (mismatches < 10) begin
                  $display("mismatch: result with nothing expected, %s %0d %0d %0d",
                           "got status, used, start:",
                           rsp_data.status, rsp_data.bit_used, rsp_data.run_start);
               end
               mismatches++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.status !== want.status || rsp_data.bit_used !== want.bit_used ||
                   rsp_data.run_start !== want.run_start) begin
                  if (mismatches < 10) begin
                     $display("mismatch: expected status %0d used %0d start %0d,",
                              want.status, want.bit_used, want.run_start,
                              " got status %0d used %0d start %0d",
                              rsp_data.status, rsp_data.bit_used, rsp_data.run_start);
                  end
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            expected_rsp_q.push_back(allocate_step(req_data));
         end
      end
      outstanding = expected_rsp_q.size();
   end

endmodule

>>> dv/tb_bitmap_run_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator testbench
// Drives directed corner requests and then phases of random test, set, clear
// and search requests under several map sizes, with random sender gaps. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_bitmap_run_allocator import bra_pkg::*;;

   localparam int LIMIT_CYCLES = 1500000;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 100;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_data;
   int         mismatches;
   int         outstanding;
   int         cycle_count = 0;

   // Map size for each random phase, including zero and values above the map.
   int phase_size [PHASES] = '{128, 4, 16, 1, 255, 0, 37, 128, 64, 200, 8, 128};

   bitmap_run_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   bra_result_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   // Units in use for a given size register value.
   function automatic int units_for(int size);
      return ((size > MAP_BYTES_DEFAULT) ? MAP_BYTES_DEFAULT : size) * 8;
   endfunction

   // Random request. Most indexes fall in a low window so that the map fills
   // densely there and searches have to scan past used units.
   function automatic req_type make_request(int units, int set_pct, int clr_pct);
      req_type r;
      int      pick;
      int      hot;
      r    = req_type'($urandom);
      pick = $urandom_range(99, 0);
      if (pick < set_pct) r.mode = MODE_SET;
      else if (pick < set_pct + clr_pct) r.mode = MODE_CLEAR;
      else if (pick < set_pct + clr_pct + 15) r.mode = MODE_TEST;
      else r.mode = MODE_SEARCH;
      if (r.mode != MODE_SEARCH) begin
         if (units == 0 || $urandom_range(9, 0) == 0) begin
            r.unit_index = 10'($urandom);
         end else begin
            hot = (units > 96 && $urandom_range(3, 0) != 0) ? 96 : units;
            r.unit_index = 10'($urandom_range(hot - 1, 0));
         end
      end else begin
         case ($urandom_range(19, 0))
            0:       r.run_length = '0;
            1:       r.run_length = 11'($urandom);
            2, 3:    r.run_length = 11'($urandom_range((units > 0) ? units : 1, 1));
            4, 5, 6: r.run_length = 11'($urandom_range(64, 13));
            default: r.run_length = 11'($urandom_range(12, 1));
         endcase
      end
      return r;
   endfunction

   // One request transfer, after an optional random gap with noise on the bus.
   task automatic send_request(req_type item, bit quiet);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(99, 0) < 35) begin
         case ($urandom_range(49, 0))
            0:          gap = $urandom_range(140, 41);
            1, 2, 3, 4: gap = $urandom_range(40, 4);
            default:    gap = $urandom_range(3, 1);
         endcase
      end
      repeat (gap) begin
         @(negedge clock);
         start    <= 1'b0;
         req_data <= req_type'($urandom);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
   endtask

   task automatic issue(logic [1:0] mode, logic [9:0] index, logic [10:0] length);
      req_type item;
      item.mode       = mode;
      item.unit_index = index;
      item.run_length = length;
      send_request(item, 1'b0);
   endtask

   // Stops sending and waits until every expected result has arrived.
   task automatic wait_for_drain();
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Size register write, only once the block is idle.
   task automatic write_size(logic [7:0] value);
      wait_for_drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int  units;
      int  set_pct;
      int  clr_pct;
      bit  quiet;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      reset     = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed corners at the reset size: ends of the map, unused fields
      // carrying junk, zero and oversized run lengths.
      issue(MODE_TEST, 10'd0, 11'd0);
      issue(MODE_SET, 10'd0, 11'd2047);
      issue(MODE_SET, 10'd1023, 11'd1024);
      issue(MODE_TEST, 10'd0, 11'd0);
      issue(MODE_TEST, 10'd1023, 11'd0);
      issue(MODE_SEARCH, 10'd1023, 11'd0);
      issue(MODE_SEARCH, 10'd0, 11'd1);
      issue(MODE_SEARCH, 10'd0, 11'd1022);
      issue(MODE_SEARCH, 10'd0, 11'd1023);
      issue(MODE_SEARCH, 10'd0, 11'd1024);
      issue(MODE_SEARCH, 10'd0, 11'd2047);
      issue(MODE_CLEAR, 10'd0, 11'd0);
      issue(MODE_SEARCH, 10'd0, 11'd1023);
      issue(MODE_CLEAR, 10'd1023, 11'd0);
      issue(MODE_SEARCH, 10'd0, 11'd1024);
      issue(MODE_TEST, 10'd1023, 11'd0);

      // Smallest nonempty size: one byte of units, indexes just past it are rejected.
      write_size(8'd1);
      issue(MODE_SET, 10'd7, 11'd0);
      issue(MODE_TEST, 10'd8, 11'd0);
      issue(MODE_SET, 10'd8, 11'd0);
      issue(MODE_CLEAR, 10'd9, 11'd0);
      issue(MODE_SEARCH, 10'd0, 11'd7);
      issue(MODE_SEARCH, 10'd0, 11'd8);

      // Zero size: nothing is in range and nothing can be found.
      write_size(8'd0);
      issue(MODE_TEST, 10'd0, 11'd0);
      issue(MODE_SEARCH, 10'd0, 11'd1);

      // Size above the map acts as the full map.
      write_size(8'd255);
      issue(MODE_TEST, 10'd7, 11'd0);

      // Random phases alternate between filling and emptying the map.
      for (int p = 0; p < PHASES; p++) begin
         write_size(8'(phase_size[p]));
         units   = units_for(phase_size[p]);
         set_pct = (p % 2 == 0) ? 45 : 15;
         clr_pct = (p % 2 == 0) ? 15 : 45;
         quiet   = (p == 6 || p == 7);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_request(make_request(units, set_pct, clr_pct), quiet);
         end
      end

      wait_for_drain();
      repeat (150) @(negedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
